// ===== rtl/dfl_pkg.sv =====
// Shared types, widths and codes of the delayed fade-in sine LFO.
// Holds the quarter-wave sine generator used to build the ROM contents.
// No dependencies.
`default_nettype none

package dfl_pkg;

    localparam int VALUE_W    = 16;
    localparam int STAGE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int PHASE_W    = 32;
    localparam int DELAY_W    = 24;
    localparam int ELAPSED_W  = 26;
    localparam int SINE_W     = 15;
    localparam int QUO_W      = 16;
    localparam int DIV_CNT_W  = 4;
    localparam int FPROD_W    = QUO_W + DELAY_W;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          SINE_SCALE  = 64'sd32767;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP = 2'd0,
        CFG_DELAY      = 2'd1,
        CFG_FADE       = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_idx_t;

    localparam logic [STAGE_W-1:0] STAGE_DELAY = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_FADE  = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_FULL  = 2'd2;

    typedef struct packed {
        logic accept;
        logic classify;
        logic rom_b;
        logic latch_a;
        logic interp_mul;
        logic interp_add;
        logic fade_mul;
        logic div_load;
        logic div_step;
        logic apply_sign;
        logic load_out;
    } dfl_cmd_t;

    typedef struct packed {
        logic in_delay;
        logic fading;
        logic div_last;
    } dfl_status_t;

    // sin(pi/2 * r / 2^qbits) scaled by 32767, Taylor series in Q30
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned r,
                                                       input int unsigned qbits);
        longint unsigned x;
        longint unsigned t;
        longint          sum;
        longint          v;
        int unsigned     k;
        x   = (HALF_PI_Q30 * 64'(r)) >> qbits;
        t   = x;
        sum = longint'(x);
        for (k = 1; k <= 8; k++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / 64'((2 * k) * (2 * k + 1));
            if (k[0])
                sum = sum - longint'(t);
            else
                sum = sum + longint'(t);
        end
        if (sum < 0)
            sum = 0;
        v = (sum * SINE_SCALE + (64'sd1 <<< 29)) >>> 30;
        if (v > SINE_SCALE)
            v = SINE_SCALE;
        return v[SINE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dfl_tick_if.sv =====
// Tick request channel of the LFO: valid, ready and the restart flag.
// Depends on nothing.
`default_nettype none

interface dfl_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

// ===== rtl/dfl_result_if.sv =====
// Result channel of the LFO: valid, ready, output value and stage.
// Depends on dfl_pkg.
`default_nettype none

interface dfl_result_if;
    import dfl_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] lfo_value;
    logic [STAGE_W-1:0]        lfo_stage;

    modport source (output valid, output lfo_value, output lfo_stage, input ready);
    modport sink (input valid, input lfo_value, input lfo_stage, output ready);
endinterface

`default_nettype wire

// ===== rtl/dfl_cfg_if.sv =====
// Configuration write channel of the LFO: valid, ready, index and data.
// Depends on dfl_pkg.
`default_nettype none

interface dfl_cfg_if;
    import dfl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dfl_sine_rom.sv =====
// Quarter-wave sine ROM with registered read, 2^(TABLE_BITS-2)+1 entries.
// Contents built at elaboration by dfl_pkg::quarter_sine.
`default_nettype none

module dfl_sine_rom #(
    parameter int TABLE_BITS = 11
) (
    input  wire logic                         clk,
    input  wire logic [TABLE_BITS-2:0]        addr,
    output      logic [dfl_pkg::SINE_W-1:0]   data
);
    import dfl_pkg::*;

    localparam int QBITS   = TABLE_BITS - 2;
    localparam int QUARTER = 1 << QBITS;
    localparam int DEPTH   = QUARTER + 1;

    logic [SINE_W-1:0] sine_q [DEPTH];
    logic [SINE_W-1:0] data_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_entry
        assign sine_q[i] = quarter_sine(i, QBITS);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= sine_q[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== rtl/dfl_ctrl.sv =====
// Sequencer of the LFO: one-hot state machine, tick and result handshakes.
// Drives datapath commands; depends on dfl_pkg.
`default_nettype none

module dfl_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  tick_valid,
    output      logic                  tick_ready,
    output      logic                  result_valid,
    input  wire logic                  result_ready,
    input  wire dfl_pkg::dfl_status_t  status,
    output      dfl_pkg::dfl_cmd_t     cmd
);
    import dfl_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_CLASS  = 11'b000_0000_0010,
        S_ADDR_A = 11'b000_0000_0100,
        S_ADDR_B = 11'b000_0000_1000,
        S_MUL    = 11'b000_0001_0000,
        S_ADD    = 11'b000_0010_0000,
        S_FMUL   = 11'b000_0100_0000,
        S_DLOAD  = 11'b000_1000_0000,
        S_DIV    = 11'b001_0000_0000,
        S_SIGN   = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (tick_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                cmd.classify = 1'b1;
                state_next   = status.in_delay ? S_DONE : S_ADDR_A;
            end
            S_ADDR_A:
            begin
                state_next = S_ADDR_B;
            end
            S_ADDR_B:
            begin
                cmd.rom_b   = 1'b1;
                cmd.latch_a = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.interp_mul = 1'b1;
                state_next     = S_ADD;
            end
            S_ADD:
            begin
                cmd.interp_add = 1'b1;
                state_next     = status.fading ? S_FMUL : S_DONE;
            end
            S_FMUL:
            begin
                cmd.fade_mul = 1'b1;
                state_next   = S_DLOAD;
            end
            S_DLOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_SIGN;
            end
            S_SIGN:
            begin
                cmd.apply_sign = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign tick_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/dfl_datapath.sv =====
// Datapath of the LFO: config registers, phase and elapsed state, sine
// lookup and interpolation, fade multiply and 16-step divider.
// Depends on dfl_pkg, dfl_cfg_if and dfl_sine_rom.
`default_nettype none

module dfl_datapath #(
    parameter int BLOCK_SIZE = 16,
    parameter int TABLE_BITS = 11
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    dfl_cfg_if.sink                            cfg,
    input  wire logic                          restart,
    input  wire dfl_pkg::dfl_cmd_t             cmd,
    output      dfl_pkg::dfl_status_t          status,
    output      logic signed [dfl_pkg::VALUE_W-1:0] lfo_value,
    output      logic [dfl_pkg::STAGE_W-1:0]   lfo_stage
);
    import dfl_pkg::*;

    localparam int FB      = PHASE_W - TABLE_BITS;
    localparam int QBITS   = TABLE_BITS - 2;
    localparam int QUARTER = 1 << QBITS;
    localparam int PROD_W  = FB + 18;
    localparam int SUM_W   = ELAPSED_W + 1;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'sd1 <<< (FB - 1));
    localparam logic signed [PROD_W-1:0] V_MAX    = PROD_W'(32767);
    localparam logic signed [PROD_W-1:0] V_MIN    = PROD_W'(-32768);

    logic [PHASE_W-1:0]        phase_step_reg;
    logic [DELAY_W-1:0]        delay_reg;
    logic [DELAY_W-1:0]        fade_reg;
    logic [PHASE_W-1:0]        phase_reg;
    logic [ELAPSED_W-1:0]      elapsed_reg;
    logic                      fading_reg;
    logic [DELAY_W-1:0]        n_reg;
    logic                      neg_reg;
    logic signed [VALUE_W-1:0] a_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [QUO_W-1:0]          mag_reg;
    logic                      sign_reg;
    logic [FPROD_W-1:0]        fprod_reg;
    logic [DELAY_W-1:0]        rem_reg;
    logic [QUO_W-1:0]          quo_reg;
    logic [DIV_CNT_W-1:0]      cnt_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [STAGE_W-1:0]        stage_reg;
    logic signed [VALUE_W-1:0] lfo_value_reg;
    logic [STAGE_W-1:0]        lfo_stage_reg;

    logic [SUM_W-1:0]          elapsed_sum;
    logic [ELAPSED_W-1:0]      elapsed_adv;
    logic                      in_delay;
    logic                      fading;
    logic [TABLE_BITS-1:0]     idx;
    logic [1:0]                quad;
    logic [QBITS-1:0]          rofs;
    logic [QBITS:0]            raddr;
    logic [SINE_W-1:0]         rom_data;
    logic signed [VALUE_W-1:0] sine_s;
    logic signed [VALUE_W:0]   diff;
    logic signed [FB:0]        frac_s;
    logic signed [PROD_W-1:0]  rnd;
    logic signed [PROD_W-1:0]  v_full;
    logic signed [VALUE_W-1:0] v_sat;
    logic [QUO_W-1:0]          mag;
    logic [DELAY_W:0]          trial;
    logic                      trial_ge;

    // elapsed bookkeeping
    assign elapsed_sum = {1'b0, elapsed_reg} + SUM_W'(BLOCK_SIZE);
    assign elapsed_adv = elapsed_sum[SUM_W-1] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
    assign in_delay    = elapsed_reg < ELAPSED_W'(delay_reg);
    assign fading      = (fade_reg != '0) &&
                         (elapsed_reg < (ELAPSED_W'(delay_reg) + ELAPSED_W'(fade_reg)));

    // ROM addressing by quarter-wave symmetry
    assign idx   = phase_reg[PHASE_W-1:FB] + TABLE_BITS'(cmd.rom_b);
    assign quad  = idx[TABLE_BITS-1:TABLE_BITS-2];
    assign rofs  = idx[QBITS-1:0];
    assign raddr = quad[0] ? ((QBITS+1)'(QUARTER) - {1'b0, rofs}) : {1'b0, rofs};

    dfl_sine_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_rom (
        .clk  (clk),
        .addr (raddr),
        .data (rom_data)
    );

    assign sine_s = neg_reg ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

    // interpolation
    assign diff   = (VALUE_W+1)'(sine_s) - (VALUE_W+1)'(a_reg);
    assign frac_s = $signed({1'b0, phase_reg[FB-1:0]});
    assign rnd    = (prod_reg + RND_HALF) >>> FB;
    assign v_full = PROD_W'(a_reg) + rnd;

    always_comb
    begin
        if (v_full > V_MAX)
            v_sat = VALUE_W'(V_MAX);
        else if (v_full < V_MIN)
            v_sat = VALUE_W'(V_MIN);
        else
            v_sat = v_full[VALUE_W-1:0];
    end

    assign mag = v_sat[VALUE_W-1] ? (~v_sat + 16'd1) : v_sat;

    // one quotient bit a step
    assign trial    = {rem_reg, quo_reg[QUO_W-1]};
    assign trial_ge = trial >= {1'b0, fade_reg};

    assign status.in_delay = in_delay;
    assign status.fading   = fading_reg;
    assign status.div_last = (cnt_reg == '1);

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            delay_reg      <= '0;
            fade_reg       <= '0;
            phase_reg      <= '0;
            elapsed_reg    <= '0;
            fading_reg     <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg_idx_t'(cfg.index))
                    CFG_PHASE_STEP: phase_step_reg <= cfg.data;
                    CFG_DELAY:      delay_reg      <= cfg.data[DELAY_W-1:0];
                    CFG_FADE:       fade_reg       <= cfg.data[DELAY_W-1:0];
                    default:        ;
                endcase
            end
            if (cmd.accept && restart)
            begin
                phase_reg   <= '0;
                elapsed_reg <= '0;
            end
            if (cmd.classify)
            begin
                fading_reg <= !in_delay && fading;
                if (in_delay || fading)
                    elapsed_reg <= elapsed_adv;
                if (!in_delay)
                    phase_reg <= phase_reg + phase_step_reg;
            end
            if (cmd.div_load)
                cnt_reg <= '0;
            else if (cmd.div_step)
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= quad[1];
        if (cmd.classify)
        begin
            n_reg <= DELAY_W'(elapsed_reg - ELAPSED_W'(delay_reg));
            if (in_delay)
            begin
                value_reg <= '0;
                stage_reg <= STAGE_DELAY;
            end
            else if (fading)
                stage_reg <= STAGE_FADE;
            else
                stage_reg <= STAGE_FULL;
        end
        if (cmd.latch_a)
            a_reg <= sine_s;
        if (cmd.interp_mul)
            prod_reg <= PROD_W'(diff) * PROD_W'(frac_s);
        if (cmd.interp_add)
        begin
            value_reg <= v_sat;
            mag_reg   <= mag;
            sign_reg  <= v_sat[VALUE_W-1];
        end
        if (cmd.fade_mul)
            fprod_reg <= FPROD_W'(mag_reg) * FPROD_W'(n_reg);
        if (cmd.div_load)
        begin
            rem_reg <= fprod_reg[FPROD_W-1:QUO_W];
            quo_reg <= fprod_reg[QUO_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? DELAY_W'(trial - {1'b0, fade_reg}) : trial[DELAY_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], trial_ge};
        end
        if (cmd.apply_sign)
            value_reg <= sign_reg ? $signed(~quo_reg + 16'd1) : $signed(quo_reg);
        if (cmd.load_out)
        begin
            lfo_value_reg <= value_reg;
            lfo_stage_reg <= stage_reg;
        end
    end

    assign lfo_value = lfo_value_reg;
    assign lfo_stage = lfo_stage_reg;

endmodule

`default_nettype wire

// ===== rtl/delayed_fade_in_sine_lfo.sv =====
// Top level of the delayed fade-in sine LFO: sequencer plus datapath.
// Depends on dfl_pkg, the channel interfaces, dfl_ctrl and dfl_datapath.
//
// Usage:
//   tick   - one request per audio block; restart=1 clears phase and elapsed
//            count before the tick is evaluated (note start).
//   result - one item per request: lfo_value (Q1.15) and lfo_stage
//            (0 delay, 1 fading in, 2 full level).
//   cfg    - register writes: 0 phase_step, 1 delay_samples, 2 fade_samples;
//            always ready, index 3 is ignored. Write only while idle.
// Delay-stage requests go from classify to the final state; full-level ones
// also pass ROM address, multiply and add; fading ones add fade multiply,
// divider load and steps, and sign. The divider resolves one quotient bit
// per cycle. A new request is taken in the cycle after the result loads.
// The result sits in an output register: a new request is accepted
// while it waits, and a stalled receiver holds the sequencer in its final
// state until the register frees. Reset clears the configuration registers,
// phase, elapsed count and result valid; no clearing pass is needed.
`default_nettype none

module delayed_fade_in_sine_lfo #(
    parameter int BLOCK_SIZE = 16,
    parameter int TABLE_BITS = 11
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    dfl_tick_if.sink      tick,
    dfl_result_if.source  result,
    dfl_cfg_if.sink       cfg
);
    import dfl_pkg::*;

    dfl_cmd_t    cmd;
    dfl_status_t status;

    dfl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick.valid),
        .tick_ready   (tick.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    dfl_datapath #(
        .BLOCK_SIZE (BLOCK_SIZE),
        .TABLE_BITS (TABLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .restart   (tick.restart),
        .cmd       (cmd),
        .status    (status),
        .lfo_value (result.lfo_value),
        .lfo_stage (result.lfo_stage)
    );

endmodule

`default_nettype wire

// ===== bench/tb_delayed_fade_in_sine_lfo.sv =====
// Self-checking bench for delayed_fade_in_sine_lfo: directed table, then random phases.
// Predicts each result from a local sine table and mirrored registers, checks in order.
// Depends on dfl_pkg, dfl_tick_if, dfl_result_if, dfl_cfg_if and the RTL top level.
`default_nettype none

module tb_delayed_fade_in_sine_lfo;
    import dfl_pkg::*;

    localparam int          BLOCK_SIZE      = 16;
    localparam int          TABLE_BITS      = 11;
    localparam int          INTERP_BITS     = PHASE_W - TABLE_BITS;
    localparam int unsigned LUT_LEN         = (1 << TABLE_BITS) + 1;
    localparam int unsigned QUARTER_LEN     = 1 << (TABLE_BITS - 2);
    localparam int unsigned ELAPSED_MAX     = (1 << ELAPSED_W) - 1;
    localparam int          PHASES          = 16;
    localparam int          TICKS_PER_PHASE = 25;
    localparam int          PRESSURE_PHASE  = 4;
    localparam int          LONG_HOLD       = 400;
    localparam int          DRAIN_CYCLES    = 40;
    localparam int unsigned WATCHDOG_LIMIT  = 3000;
    localparam int          DIR_ROWS        = 34;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [STAGE_W-1:0]        stage;
    } lfo_sample_t;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        cfg_idx_t             reg_idx;
        logic [CFG_DATA_W-1:0] data;
        logic                 restart;
        logic                 typed;
        lfo_sample_t          exp_out;
    } stim_row_t;

    logic clk;
    logic rst_n;

    dfl_tick_if   tick_ch ();
    dfl_result_if result_ch ();
    dfl_cfg_if    cfg_ch ();

    delayed_fade_in_sine_lfo #(
        .BLOCK_SIZE (BLOCK_SIZE),
        .TABLE_BITS (TABLE_BITS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    logic signed [VALUE_W-1:0] sine_lut [LUT_LEN];

    logic [PHASE_W-1:0]   pred_step;
    logic [DELAY_W-1:0]   pred_delay;
    logic [DELAY_W-1:0]   pred_fade;
    logic [PHASE_W-1:0]   pred_phase;
    logic [ELAPSED_W-1:0] pred_elapsed;

    lfo_sample_t lfo_expect_q [$];
    int unsigned mismatch_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_requests;
    int          holds_done;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b0, 1'b1, '{16'sd0, STAGE_FULL}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b1, 1'b1, '{16'sd0, STAGE_FULL}},
        '{ROW_WRITE, CFG_PHASE_STEP, 32'h4000_0000, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b1, 1'b1, '{16'sd32767, STAGE_FULL}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b0, 1'b1, '{16'sd0, STAGE_FULL}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b0, 1'b1, '{-16'sd32767, STAGE_FULL}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b0, 1'b1, '{16'sd0, STAGE_FULL}},
        '{ROW_WRITE, CFG_DELAY,      32'hFF00_0020, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_WRITE, CFG_FADE,       32'hFF00_0030, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b1, 1'b1, '{16'sd0, STAGE_DELAY}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b0, 1'b1, '{16'sd0, STAGE_DELAY}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b0, 1'b1, '{16'sd0, STAGE_FADE}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_WRITE, CFG_DELAY,      32'h0000_0400, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b0, 1'b1, '{16'sd0, STAGE_DELAY}},
        '{ROW_WRITE, CFG_UNUSED,     32'hFFFF_FFFF, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_WRITE, CFG_PHASE_STEP, 32'hFFFF_FFFF, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_WRITE, CFG_DELAY,      32'h0000_0000, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_WRITE, CFG_FADE,       32'h00FF_FFFF, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b1, 1'b1, '{16'sd0, STAGE_FADE}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_WRITE, CFG_FADE,       32'h0000_0000, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_WRITE, CFG_DELAY,      32'h00FF_FFFF, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b1, 1'b1, '{16'sd0, STAGE_DELAY}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b0, 1'b1, '{16'sd0, STAGE_DELAY}},
        '{ROW_WRITE, CFG_DELAY,      32'h0000_0000, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_WRITE, CFG_PHASE_STEP, 32'h0000_0001, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b1, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_WRITE, CFG_PHASE_STEP, 32'h0A3D_70A4, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}},
        '{ROW_TICK,  CFG_PHASE_STEP, 32'h0000_0000, 1'b0, 1'b0, '{16'sd0, STAGE_DELAY}}
    };

    function automatic int sine_quarter_q15(input int unsigned r);
        longint unsigned x;
        longint unsigned t;
        longint          sum;
        longint          v;
        int unsigned     k;
        x   = (HALF_PI_Q30 * 64'(r)) / 64'(QUARTER_LEN);
        t   = x;
        sum = longint'(x);
        for (k = 1; k <= 8; k++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                sum = sum - longint'(t);
            else
                sum = sum + longint'(t);
        end
        if (sum < 0)
            sum = 0;
        v = (sum * 32767 + (64'sd1 << 29)) / (64'sd1 << 30);
        if (v > 32767)
            v = 32767;
        return int'(v);
    endfunction

    function automatic void bump_elapsed();
        if (32'(pred_elapsed) + BLOCK_SIZE > ELAPSED_MAX)
            pred_elapsed = ELAPSED_W'(ELAPSED_MAX);
        else
            pred_elapsed = pred_elapsed + ELAPSED_W'(BLOCK_SIZE);
    endfunction

    function automatic lfo_sample_t lfo_predict(input logic restart);
        lfo_sample_t     res;
        int unsigned     idx;
        int unsigned     frac;
        longint          a;
        longint          b;
        longint          v;
        longint unsigned mag;
        longint unsigned span;
        if (restart)
        begin
            pred_phase   = '0;
            pred_elapsed = '0;
        end
        if (pred_elapsed < pred_delay)
        begin
            bump_elapsed();
            res.value = '0;
            res.stage = STAGE_DELAY;
            return res;
        end
        pred_phase = pred_phase + pred_step;
        idx        = pred_phase >> INTERP_BITS;
        frac       = pred_phase & ((32'd1 << INTERP_BITS) - 1);
        a          = sine_lut[idx];
        b          = sine_lut[idx + 1];
        v = a + (((b - a) * longint'(frac) + (64'sd1 <<< (INTERP_BITS - 1))) >>> INTERP_BITS);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        res.stage = STAGE_FULL;
        if (pred_fade != 0 && 32'(pred_elapsed) < 32'(pred_delay) + 32'(pred_fade))
        begin
            span = 64'(pred_elapsed) - 64'(pred_delay);
            mag  = (v < 0) ? 64'(-v) : 64'(v);
            mag  = (mag * span) / 64'(pred_fade);
            v    = (v < 0) ? -longint'(mag) : longint'(mag);
            bump_elapsed();
            res.stage = STAGE_FADE;
        end
        res.value = v[VALUE_W-1:0];
        return res;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_span();
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom();
        case ($urandom_range(0, 9))
            0: return {junk[31:24], 24'h00_0000};
            1: return {junk[31:24], 24'hFF_FFFF};
            2: return junk;
            default: return {junk[31:24], 24'($urandom_range(0, 400))};
        endcase
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_PHASE_STEP: pred_step  = data;
            CFG_DELAY:      pred_delay = data[DELAY_W-1:0];
            CFG_FADE:       pred_fade  = data[DELAY_W-1:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_tick(input logic restart, input logic typed,
                             input lfo_sample_t typed_out);
        lfo_sample_t got;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        tick_ch.valid   <= 1'b1;
        tick_ch.restart <= restart;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        got = lfo_predict(restart);
        lfo_expect_q.push_back(typed ? typed_out : got);
    endtask

    task automatic settle();
        tick_ch.valid <= 1'b0;
        while (lfo_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        int unsigned           q;
        int unsigned           r;
        int                    s;
        logic [CFG_DATA_W-1:0] step;
        logic                  restart;
        lfo_sample_t           unused_out;

        for (int i = 0; i < LUT_LEN; i++)
        begin
            q = (i % (1 << TABLE_BITS)) / QUARTER_LEN;
            r = (i % (1 << TABLE_BITS)) % QUARTER_LEN;
            case (q)
                0: s = sine_quarter_q15(r);
                1: s = sine_quarter_q15(QUARTER_LEN - r);
                2: s = -sine_quarter_q15(r);
                default: s = -sine_quarter_q15(QUARTER_LEN - r);
            endcase
            sine_lut[i] = VALUE_W'(s);
        end
        pred_step      = '0;
        pred_delay     = '0;
        pred_fade      = '0;
        pred_phase     = '0;
        pred_elapsed   = '0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        holds_done     = 0;
        unused_out     = '0;

        rst_n           <= 1'b0;
        tick_ch.valid   <= 1'b0;
        tick_ch.restart <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_PHASE_STEP;
        cfg_ch.data     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].data);
            end
            else
                send_tick(dir_rows[i].restart, dir_rows[i].typed, dir_rows[i].exp_out);
        end

        for (int phase_no = 0; phase_no < PHASES; phase_no++)
        begin
            settle();
            case (phase_no % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 71;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 71;
                end
                default:
                begin
                    send_idle_pct  = 28;
                    recv_stall_pct = 28;
                end
            endcase
            if ($urandom_range(0, 4) != 0)
            begin
                case ($urandom_range(0, 5))
                    0: step = '0;
                    1: step = '1;
                    2: step = $urandom_range(0, 32'h0100_0000);
                    default: step = $urandom();
                endcase
                write_reg(CFG_PHASE_STEP, step);
            end
            if ($urandom_range(0, 4) != 0)
                write_reg(CFG_DELAY, pick_span());
            if ($urandom_range(0, 4) != 0)
                write_reg(CFG_FADE, pick_span());
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_UNUSED, $urandom());
            if (phase_no == PRESSURE_PHASE)
            begin
                send_idle_pct = 0;
                hold_requests++;
            end
            for (int n = 0; n < TICKS_PER_PHASE; n++)
            begin
                if (n == 0)
                    restart = ($urandom_range(0, 3) != 0);
                else
                    restart = ($urandom_range(0, 15) == 0);
                send_tick(restart, 1'b0, unused_out);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[delayed_fade_in_sine_lfo] OK");
        else
            $display("[delayed_fade_in_sine_lfo] ERROR");
        $finish;
    end

    initial
    begin
        lfo_sample_t want;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                if (lfo_expect_q.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, got value %0d stage %0d",
                             $time, result_ch.lfo_value, result_ch.lfo_stage);
                    mismatch_count++;
                end
                else
                begin
                    want = lfo_expect_q.pop_front();
                    if (result_ch.lfo_value !== want.value)
                    begin
                        $display("%0t lfo_value mismatch: expected %0d, got %0d",
                                 $time, want.value, result_ch.lfo_value);
                        mismatch_count++;
                    end
                    if (result_ch.lfo_stage !== want.stage)
                    begin
                        $display("%0t lfo_stage mismatch: expected %0d, got %0d",
                                 $time, want.stage, result_ch.lfo_stage);
                        mismatch_count++;
                    end
                end
            end
            // hold off the receiver long enough to back up the tick channel
            if (holds_done < hold_requests)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[delayed_fade_in_sine_lfo] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
